### rtl/assert_macros.svh
// Assertion macros shared by the response frame checker RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RFC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("response frame checker: assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define RFC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("response frame checker: assertion failed");

`endif

### rtl/rfc_pkg.sv
// Types and constants of the response frame checker.
// No dependencies; imported by every module of the block.
package rfc_pkg;

  // Frame bytes
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] BYTE_APP  = 8'h01;
  localparam logic [7:0] BYTE_TFI  = 8'hD5;

  // Register reset values
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd264;
  localparam logic [7:0]  EXP_CMD_RST     = 8'd0;

  // Configuration register indexes
  typedef enum logic {
    REG_MAX_PAYLOAD = 1'b0,
    REG_EXP_CMD     = 1'b1
  } reg_idx_e;

  // Final status codes
  typedef enum logic [3:0] {
    ST_OK    = 4'd0,
    ST_PRE   = 4'd1,
    ST_APP   = 4'd2,
    ST_LSUM  = 4'd3,
    ST_LEN   = 4'd4,
    ST_ID    = 4'd5,
    ST_CODE  = 4'd6,
    ST_DSUM  = 4'd7,
    ST_POST  = 4'd8,
    ST_TRUNC = 4'd9
  } status_e;

  // Parser phases
  typedef enum logic [3:0] {
    PH_PRE0    = 4'd0,
    PH_PRE1    = 4'd1,
    PH_PRE2    = 4'd2,
    PH_KIND0   = 4'd3,
    PH_KIND1   = 4'd4,
    PH_APPCODE = 4'd5,
    PH_EXT_LH  = 4'd6,
    PH_EXT_LL  = 4'd7,
    PH_EXT_LCS = 4'd8,
    PH_TFI     = 4'd9,
    PH_CODE    = 4'd10,
    PH_PAYLOAD = 4'd11,
    PH_DCS     = 4'd12,
    PH_POST    = 4'd13
  } phase_e;

  typedef struct packed {
    logic [15:0] max_payload;
    logic [7:0]  expected_command;
  } cfg_t;

  typedef struct packed {
    logic        is_final;
    logic [7:0]  payload_byte;
    status_e     status;
    logic [7:0]  app_error_code;
    logic [15:0] payload_length;
  } res_t;

endpackage

### rtl/rfc_cfg_regs.sv
// Configuration registers of the response frame checker.
// Depends on rfc_pkg for the register indexes and the cfg_t bundle.
module rfc_cfg_regs import rfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_MAX_PAYLOAD: cfg_d.max_payload      = cfg_wdata_i;
        REG_EXP_CMD:     cfg_d.expected_command = cfg_wdata_i[7:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_payload      <= MAX_PAYLOAD_RST;
      cfg_q.expected_command <= EXP_CMD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/rfc_parser.sv
// Frame parser: phase state, length and checksum tracking, result decision.
// Depends on rfc_pkg; fed one word per advance by the top level input register.
module rfc_parser import rfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic [7:0] byte_i,
  input  logic       end_i,
  input  cfg_t       cfg_i,
  output logic       has_result_o,
  output res_t       result_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  hold_q, hold_d;
  logic [7:0]  sum_q, sum_d;
  logic        done_q, done_d;

  logic        closed, pay;
  status_e     st;
  logic [7:0]  code;
  logic [15:0] plen;
  logic [7:0]  lsum;

  // Length below two, or payload above the limit
  function automatic logic length_bad(input logic [15:0] len, input logic [15:0] lim);
    logic [15:0] pl;
    pl = len - 16'd2;
    return (len < 16'd2) || (pl > lim);
  endfunction

  // Work out the next state and the verdict for this word
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    len_d   = len_q;
    hold_d  = hold_q;
    sum_d   = sum_q;
    done_d  = done_q;
    closed  = 1'b0;
    pay     = 1'b0;
    st      = ST_OK;
    code    = 8'h00;
    plen    = 16'h0000;
    lsum    = 8'h00;

    if (!done_q) begin
      unique case (phase_q)
        PH_PRE0: begin
          if (byte_i == BYTE_ZERO) phase_d = PH_PRE1;
          else begin closed = 1'b1; st = ST_PRE; end
        end
        PH_PRE1: begin
          if (byte_i == BYTE_ZERO) phase_d = PH_PRE2;
          else begin closed = 1'b1; st = ST_PRE; end
        end
        PH_PRE2: begin
          if (byte_i == BYTE_FF) phase_d = PH_KIND0;
          else begin closed = 1'b1; st = ST_PRE; end
        end
        PH_KIND0: begin
          hold_d  = byte_i;
          phase_d = PH_KIND1;
        end
        PH_KIND1: begin
          lsum = hold_q + byte_i;
          priority if (hold_q == BYTE_APP && byte_i == BYTE_FF) begin
            phase_d = PH_APPCODE;
          end else if (hold_q == BYTE_FF && byte_i == BYTE_FF) begin
            phase_d = PH_EXT_LH;
          end else if (lsum != 8'h00) begin
            closed = 1'b1; st = ST_LSUM;
          end else begin
            len_d = {8'h00, hold_q};
            if (length_bad({8'h00, hold_q}, cfg_i.max_payload)) begin
              closed = 1'b1; st = ST_LEN;
            end else phase_d = PH_TFI;
          end
        end
        PH_APPCODE: begin
          closed = 1'b1; st = ST_APP; code = byte_i;
        end
        PH_EXT_LH: begin
          hold_d  = byte_i;
          phase_d = PH_EXT_LL;
        end
        PH_EXT_LL: begin
          len_d   = {hold_q, byte_i};
          phase_d = PH_EXT_LCS;
        end
        PH_EXT_LCS: begin
          lsum = hold_q + len_q[7:0] + byte_i;
          if (lsum != 8'h00) begin
            closed = 1'b1; st = ST_LSUM;
          end else if (length_bad(len_q, cfg_i.max_payload)) begin
            closed = 1'b1; st = ST_LEN;
          end else phase_d = PH_TFI;
        end
        PH_TFI: begin
          if (byte_i != BYTE_TFI) begin
            closed = 1'b1; st = ST_ID;
          end else begin
            sum_d   = byte_i;
            phase_d = PH_CODE;
          end
        end
        PH_CODE: begin
          // a command of FF has no valid response code
          if (cfg_i.expected_command != BYTE_FF &&
              byte_i == cfg_i.expected_command + 8'd1) begin
            sum_d   = sum_q + byte_i;
            pos_d   = 16'h0000;
            phase_d = (len_q == 16'd2) ? PH_DCS : PH_PAYLOAD;
          end else begin
            closed = 1'b1; st = ST_CODE;
          end
        end
        PH_PAYLOAD: begin
          sum_d = sum_q + byte_i;
          pay   = 1'b1;
          pos_d = pos_q + 16'd1;
          if (pos_d == len_q - 16'd2) phase_d = PH_DCS;
        end
        PH_DCS: begin
          lsum = sum_q + byte_i;
          if (lsum != 8'h00) begin
            closed = 1'b1; st = ST_DSUM;
          end else phase_d = PH_POST;
        end
        default: begin
          // postamble, and any phase code that means nothing
          closed = 1'b1;
          if (byte_i == BYTE_ZERO) plen = len_q - 16'd2;
          else st = ST_POST;
        end
      endcase
    end

    if (closed) done_d = 1'b1;

    // restart the frame after the last word of a read
    if (end_i) begin
      phase_d = PH_PRE0;
      pos_d   = 16'h0000;
      len_d   = 16'h0000;
      hold_d  = 8'h00;
      sum_d   = 8'h00;
      done_d  = 1'b0;
    end
  end

  // Build the result word
  always_comb begin
    result_o     = '{is_final: 1'b1, payload_byte: 8'h00, status: ST_OK,
                     app_error_code: 8'h00, payload_length: 16'h0000};
    has_result_o = 1'b0;
    if (!done_q) begin
      priority if (closed) begin
        has_result_o            = 1'b1;
        result_o.status         = st;
        result_o.app_error_code = code;
        result_o.payload_length = plen;
      end else if (end_i) begin
        has_result_o    = 1'b1;
        result_o.status = ST_TRUNC;
      end else if (pay) begin
        has_result_o          = 1'b1;
        result_o.is_final     = 1'b0;
        result_o.payload_byte = byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PRE0;
      pos_q   <= 16'h0000;
      len_q   <= 16'h0000;
      hold_q  <= 8'h00;
      sum_q   <= 8'h00;
      done_q  <= 1'b0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      hold_q  <= hold_d;
      sum_q   <= sum_d;
      done_q  <= done_d;
    end
  end

endmodule

### rtl/rfc_out_reg.sv
// Result register of the response frame checker, with valid/ready output.
// Depends on rfc_pkg for the res_t result word.
module rfc_out_reg import rfc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  input  logic out_ready_i,
  output logic free_o,
  output logic out_valid_o,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  // Slot is free when empty or being taken this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) valid_d = 1'b1;
    else if (out_ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  // Hold payload until a new word is loaded
  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

### rtl/response_frame_checker.sv
// Top level of the response frame checker: input register, parser, result register.
// Depends on rfc_pkg, rfc_cfg_regs, rfc_parser, rfc_out_reg and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one frame byte per word,
//   rx_byte_i, with read_end_i marking the last byte of a bus read.
//   Output channel (out_valid_o/out_ready_i) carries at most one result word
//   per input word: a tentative payload byte (out_is_final_o low) or a final
//   status that closes the frame. Words after a closed frame give no result
//   until read_end_i, after which the parser waits for a new preamble.
//   An accepted word sits in the input register; its result is loaded into the
//   result register when the word advances and is offered from then on.
//   Throughput: one word per cycle while the result register is not stalled, set
//   by the single parser step between the input register and the result register.
//   A stalled receiver holds the result register; the input register still
//   drains words that give no result, otherwise in_ready_o drops.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0 max
//   payload, 1 expected command); the user must write only while the block is idle,
//   which the block does not enforce. Reset (rst_ni low) empties both registers,
//   restarts the parser and sets max payload to 264 and expected command to 0.
`include "assert_macros.svh"

module response_frame_checker import rfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        read_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_is_final_o,
  output logic [7:0]  out_payload_byte_o,
  output logic [3:0]  out_status_o,
  output logic [7:0]  out_app_error_code_o,
  output logic [15:0] out_payload_length_o
);

  cfg_t       cfg;
  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       end_q;
  logic       advance, has_result, out_free;
  res_t       res_new, res_out;

  rfc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Advance the held word unless it needs the result slot and that is full
  assign advance    = in_valid_q && (!has_result || out_free);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_valid_q <= 1'b0;
    else in_valid_q <= in_valid_d;
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
      end_q  <= read_end_i;
    end
  end

  rfc_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .byte_i       (byte_q),
    .end_i        (end_q),
    .cfg_i        (cfg),
    .has_result_o (has_result),
    .result_o     (res_new)
  );

  rfc_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && has_result),
    .res_i       (res_new),
    .out_ready_i (out_ready_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .res_o       (res_out)
  );

  assign out_is_final_o       = res_out.is_final;
  assign out_payload_byte_o   = res_out.payload_byte;
  assign out_status_o         = res_out.status;
  assign out_app_error_code_o = res_out.app_error_code;
  assign out_payload_length_o = res_out.payload_length;

  // Input stalls only behind a full, stalled result register
  `RFC_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)
  // Payload words carry no status, code or length
  `RFC_ASSERT_IMPL(a_payload_clean, clk_i, rst_ni, out_valid_o && !out_is_final_o,
                   out_status_o == ST_OK && out_app_error_code_o == 8'h00 &&
                   out_payload_length_o == 16'h0000)
  // A word that leaves the input register with a result fills the output
  `RFC_ASSERT_NEXT(a_result_lands, clk_i, rst_ni, advance && has_result, out_valid_o)

endmodule
